[hdl/hcl_pkg.sv]
// Shared widths, constants, register codes and queue item types of the input linearizer.
`timescale 1ns / 1ps
`default_nettype none

package hcl_pkg;

  // Field widths
  localparam int VOLT_W     = 14;
  localparam int KNEE_W     = 15;
  localparam int LEVEL_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Product of a 15-bit factor and a 14-bit voltage difference
  localparam int NUM_W = KNEE_W + VOLT_W;

  // Full scale level, +1.0 in Q1.14
  localparam int LEVEL_ONE = 16384;

  // Knee voltage between the two forward gas slopes, Q2.12
  localparam logic [VOLT_W-1:0] GAS_KNEE_VOLT = 14'd6018;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [VOLT_W-1:0] GAS_DEAD_LOW_RST   = 14'd6024;
  localparam logic [VOLT_W-1:0] REVERSE_THR_RST    = 14'd6881;
  localparam logic [VOLT_W-1:0] GAS_REVERSE_MAX_RST = 14'd8602;
  localparam logic [VOLT_W-1:0] GAS_FULL_RST       = 14'd3727;
  localparam logic [KNEE_W-1:0] KNEE_LEVEL_RST     = 15'd6226;
  localparam logic [VOLT_W-1:0] TURN_CENTER_RST    = 14'd6267;
  localparam logic [VOLT_W-1:0] TURN_HIGH_RST      = 14'd11878;
  localparam logic [VOLT_W-1:0] TURN_LOW_RST       = 14'd696;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAS_DEAD_LOW    = 3'd0,
    CFG_REVERSE_THR     = 3'd1,
    CFG_GAS_REVERSE_MAX = 3'd2,
    CFG_GAS_FULL        = 3'd3,
    CFG_KNEE_LEVEL      = 3'd4,
    CFG_TURN_CENTER     = 3'd5,
    CFG_TURN_HIGH       = 3'd6,
    CFG_TURN_LOW        = 3'd7
  } cfg_idx_t;

  // Configuration register file contents
  typedef struct packed {
    logic [VOLT_W-1:0] gas_dead_low_volt;
    logic [VOLT_W-1:0] reverse_threshold_volt;
    logic [VOLT_W-1:0] gas_reverse_max_volt;
    logic [VOLT_W-1:0] gas_full_volt;
    logic [KNEE_W-1:0] knee_level;
    logic [VOLT_W-1:0] turn_center_volt;
    logic [VOLT_W-1:0] turn_high_volt;
    logic [VOLT_W-1:0] turn_low_volt;
  } cfg_t;

  // One channel's division job: level = base +/- num / den
  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [VOLT_W-1:0] den;
    logic              neg;
    logic [KNEE_W-1:0] base;
    logic              bad;
  } job_t;

  // Queue item: both channels of one sample pair
  typedef struct packed {
    job_t gas;
    job_t turn;
  } job_pair_t;

endpackage

`default_nettype wire

[hdl/hcl_if.sv]
// Valid/ready channel interfaces for sample pairs and level results.
`timescale 1ns / 1ps
`default_nettype none

interface hcl_in_if;
  logic                            valid;
  logic                            ready;
  logic [hcl_pkg::VOLT_W-1:0]      gas_sample;
  logic [hcl_pkg::VOLT_W-1:0]      turn_sample;

  modport source (output valid, output gas_sample, output turn_sample, input ready);
  modport sink (input valid, input gas_sample, input turn_sample, output ready);
endinterface

interface hcl_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [hcl_pkg::LEVEL_W-1:0] gas_level;
  logic signed [hcl_pkg::LEVEL_W-1:0] turn_level;
  logic                               gas_out_of_range;
  logic                               turn_out_of_range;

  modport source (output valid, output gas_level, output turn_level,
                  output gas_out_of_range, output turn_out_of_range, input ready);
  modport sink (input valid, input gas_level, input turn_level,
                input gas_out_of_range, input turn_out_of_range, output ready);
endinterface

`default_nettype wire

[hdl/hcl_front.sv]
// Front end: sample smoothing, region classification and numerator product.
`timescale 1ns / 1ps
`default_nettype none

module hcl_front (
  input  wire logic               clk,
  input  wire logic               rst,
  hcl_in_if.sink                  samples,
  input  wire hcl_pkg::cfg_t      cfg,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output hcl_pkg::job_pair_t      push_data
);

  localparam int VW = hcl_pkg::VOLT_W;
  localparam int KW = hcl_pkg::KNEE_W;
  localparam logic [KW-1:0] ONE = KW'(hcl_pkg::LEVEL_ONE);

  // Multiplier operands of one channel
  typedef struct packed {
    logic [KW-1:0] op_a;
    logic [VW-1:0] op_b;
    logic [VW-1:0] den;
    logic          neg;
    logic [KW-1:0] base;
    logic          bad;
  } mul_op_t;

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_CLASS = 3'b010,
    F_MULT  = 3'b100
  } front_state_t;

  front_state_t      state;
  logic [VW-1:0]     gas_avg;
  logic [VW-1:0]     turn_avg;
  mul_op_t           gas_op;
  mul_op_t           turn_op;
  mul_op_t           gas_op_next;
  mul_op_t           turn_op_next;
  logic              accept;

  assign samples.ready = (state == F_IDLE);
  assign accept        = samples.valid && samples.ready;

  // Classify the smoothed gas voltage
  always_comb begin
    gas_op_next = '{op_a: '0, op_b: '0, den: VW'(1), neg: 1'b0, base: '0, bad: 1'b0};
    if (gas_avg <= cfg.reverse_threshold_volt && gas_avg >= cfg.gas_dead_low_volt) begin
      gas_op_next.bad = 1'b0;
    end else if (gas_avg > cfg.reverse_threshold_volt &&
                 gas_avg <= cfg.gas_reverse_max_volt) begin
      gas_op_next.op_a = ONE;
      gas_op_next.op_b = gas_avg - cfg.reverse_threshold_volt;
      gas_op_next.den  = cfg.gas_reverse_max_volt - cfg.reverse_threshold_volt;
      gas_op_next.neg  = 1'b1;
    end else if (gas_avg < cfg.gas_dead_low_volt && gas_avg >= hcl_pkg::GAS_KNEE_VOLT) begin
      gas_op_next.op_a = cfg.knee_level;
      gas_op_next.op_b = cfg.gas_dead_low_volt - gas_avg;
      gas_op_next.den  = cfg.gas_dead_low_volt - hcl_pkg::GAS_KNEE_VOLT;
    end else if (gas_avg < hcl_pkg::GAS_KNEE_VOLT && gas_avg >= cfg.gas_full_volt) begin
      // Second slope: remaining span above the knee may be negative
      if (cfg.knee_level > ONE) begin
        gas_op_next.op_a = cfg.knee_level - ONE;
        gas_op_next.neg  = 1'b1;
      end else begin
        gas_op_next.op_a = ONE - cfg.knee_level;
      end
      gas_op_next.op_b = hcl_pkg::GAS_KNEE_VOLT - gas_avg;
      gas_op_next.den  = hcl_pkg::GAS_KNEE_VOLT - cfg.gas_full_volt;
      gas_op_next.base = cfg.knee_level;
    end else begin
      gas_op_next.bad = 1'b1;
    end
  end

  // Classify the smoothed turn voltage about its center
  always_comb begin
    turn_op_next = '{op_a: '0, op_b: '0, den: VW'(1), neg: 1'b0, base: '0, bad: 1'b0};
    if (turn_avg == cfg.turn_center_volt) begin
      turn_op_next.bad = 1'b0;
    end else if (turn_avg > cfg.turn_center_volt && turn_avg <= cfg.turn_high_volt) begin
      turn_op_next.op_a = ONE;
      turn_op_next.op_b = turn_avg - cfg.turn_center_volt;
      turn_op_next.den  = cfg.turn_high_volt - cfg.turn_center_volt;
    end else if (turn_avg < cfg.turn_center_volt && turn_avg >= cfg.turn_low_volt) begin
      turn_op_next.op_a = ONE;
      turn_op_next.op_b = cfg.turn_center_volt - turn_avg;
      turn_op_next.den  = cfg.turn_center_volt - cfg.turn_low_volt;
      turn_op_next.neg  = 1'b1;
    end else begin
      turn_op_next.bad = 1'b1;
    end
  end

  // Sequence: accept and smooth, classify, multiply and push
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      gas_avg  <= '0;
      turn_avg <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            gas_avg  <= VW'(({1'b0, samples.gas_sample} + {1'b0, gas_avg}) >> 1);
            turn_avg <= VW'(({1'b0, samples.turn_sample} + {1'b0, turn_avg}) >> 1);
            state    <= F_CLASS;
          end
        end
        F_CLASS: begin
          state <= F_MULT;
        end
        F_MULT: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Hold classified operands
  always_ff @(posedge clk) begin
    if (state == F_CLASS) begin
      gas_op  <= gas_op_next;
      turn_op <= turn_op_next;
    end
  end

  // Form numerators; the queue register follows the multipliers
  assign push_valid          = (state == F_MULT);
  assign push_data.gas.num   = gas_op.op_a * gas_op.op_b;
  assign push_data.gas.den   = gas_op.den;
  assign push_data.gas.neg   = gas_op.neg;
  assign push_data.gas.base  = gas_op.base;
  assign push_data.gas.bad   = gas_op.bad;
  assign push_data.turn.num  = turn_op.op_a * turn_op.op_b;
  assign push_data.turn.den  = turn_op.den;
  assign push_data.turn.neg  = turn_op.neg;
  assign push_data.turn.base = turn_op.base;
  assign push_data.turn.bad  = turn_op.bad;

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> !samples.ready && state == F_CLASS)
    else $error("front took a second transfer while busy");

endmodule

`default_nettype wire

[hdl/hcl_queue.sv]
// Short register queue of division jobs between front and back.
`timescale 1ns / 1ps
`default_nettype none

module hcl_queue #(
  parameter int DEPTH = hcl_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire hcl_pkg::job_pair_t push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output hcl_pkg::job_pair_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hcl_pkg::job_pair_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[hdl/hcl_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module hcl_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [hcl_pkg::NUM_W-1:0]   num,
  input  wire logic [hcl_pkg::VOLT_W-1:0]  den,
  output logic                             busy,
  output logic [hcl_pkg::NUM_W-1:0]        quotient
);

  localparam int NW    = hcl_pkg::NUM_W;
  localparam int VW    = hcl_pkg::VOLT_W;
  localparam int CNT_W = $clog2(NW);

  logic [NW-1:0]    quo;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    divisor;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      rem_shift;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  assign rem_shift = {rem, quo[NW-1]};
  assign fits      = (rem_shift >= {1'b0, divisor});
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(NW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      quo <= {quo[NW-2:0], fits};
      rem <= fits ? VW'(rem_shift - {1'b0, divisor}) : VW'(rem_shift);
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == '0)
    else $error("divider did not begin after start");

endmodule

`default_nettype wire

[hdl/hcl_back.sv]
// Back end: divides both channels, applies sign, offset (gas only) and clamp, holds the result.
`timescale 1ns / 1ps
`default_nettype none

module hcl_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire hcl_pkg::job_pair_t pop_data,
  hcl_out_if.source               levels
);

  localparam int NW = hcl_pkg::NUM_W;
  localparam int KW = hcl_pkg::KNEE_W;
  localparam int LW = hcl_pkg::LEVEL_W;
  localparam int SW = NW + 2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } back_state_t;

  back_state_t        state;
  logic               start;
  logic               gas_busy;
  logic               turn_busy;
  logic [NW-1:0]      gas_quo;
  logic [NW-1:0]      turn_quo;
  logic               gas_neg;
  logic               turn_neg;
  logic [KW-1:0]      gas_base;
  logic               gas_bad;
  logic               turn_bad;
  logic               load;

  // Signed level from quotient, clamped to +/-1.0
  function automatic logic [LW-1:0] make_level(input logic [NW-1:0] q, input logic neg,
                                               input logic [KW-1:0] base);
    logic signed [SW-1:0] mag;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] one;
    one = SW'(hcl_pkg::LEVEL_ONE);
    mag = $signed({2'b00, q});
    sum = (neg ? -mag : mag) + $signed({{(SW - KW){1'b0}}, base});
    if (sum > one) begin
      return LW'(one);
    end else if (sum < -one) begin
      return LW'(-one);
    end
    return LW'(sum);
  endfunction

  assign pop_ready = (state == S_IDLE);
  assign start     = pop_valid && pop_ready;
  assign load      = (state == S_DONE) && (!levels.valid || levels.ready);

  hcl_div u_gas_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .num      (pop_data.gas.num),
    .den      (pop_data.gas.den),
    .busy     (gas_busy),
    .quotient (gas_quo)
  );

  hcl_div u_turn_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .num      (pop_data.turn.num),
    .den      (pop_data.turn.den),
    .busy     (turn_busy),
    .quotient (turn_quo)
  );

  // Sequence: take a job, divide, hand over the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!gas_busy && !turn_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold sign, offset and range flags of the job in work
  always_ff @(posedge clk) begin
    if (start) begin
      gas_neg  <= pop_data.gas.neg;
      gas_base <= pop_data.gas.base;
      gas_bad  <= pop_data.gas.bad;
      turn_neg <= pop_data.turn.neg;
      turn_bad <= pop_data.turn.bad;
    end
  end

  // Output register: free once its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      levels.valid <= 1'b0;
    end else if (load) begin
      levels.valid <= 1'b1;
    end else if (levels.ready) begin
      levels.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      levels.gas_level         <= make_level(gas_quo, gas_neg, gas_base);
      levels.turn_level        <= make_level(turn_quo, turn_neg, '0);
      levels.gas_out_of_range  <= gas_bad;
      levels.turn_out_of_range <= turn_bad;
    end
  end

  a_gas_flag_zero: assert property (@(posedge clk) disable iff (rst)
    levels.valid && levels.gas_out_of_range |-> levels.gas_level == '0)
    else $error("gas out of range with nonzero level");

  a_turn_flag_zero: assert property (@(posedge clk) disable iff (rst)
    levels.valid && levels.turn_out_of_range |-> levels.turn_level == '0)
    else $error("turn out of range with nonzero level");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    gas_busy == turn_busy)
    else $error("channel dividers out of step");

endmodule

`default_nettype wire

[hdl/hand_controller_input_linearizer.sv]
// Top level: configuration registers, front end, job queue and back end.
// A sample pair passes the front (smooth, classify, push), the queue pop, 29 divider steps,
//   the done check and the output register before its result is valid.
// The back end sets the rate: it takes no new pair until the last has passed its start,
//   29 restoring divider steps, done check and output load.
// The front takes a new pair once it has pushed the last one, while the queue has room.
// Reset (rst, synchronous): averages clear to zero, registers take their defaults,
//   queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module hand_controller_input_linearizer #(
  parameter int QUEUE_DEPTH = hcl_pkg::QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  hcl_in_if.sink                                 samples,
  hcl_out_if.source                              levels,
  input  wire logic                              cfg_wr_en,
  input  wire logic [hcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hcl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int VW = hcl_pkg::VOLT_W;
  localparam int KW = hcl_pkg::KNEE_W;

  hcl_pkg::cfg_t      cfg;
  logic               push_valid;
  logic               push_ready;
  hcl_pkg::job_pair_t push_data;
  logic               pop_valid;
  logic               pop_ready;
  hcl_pkg::job_pair_t pop_data;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gas_dead_low_volt      <= hcl_pkg::GAS_DEAD_LOW_RST;
      cfg.reverse_threshold_volt <= hcl_pkg::REVERSE_THR_RST;
      cfg.gas_reverse_max_volt   <= hcl_pkg::GAS_REVERSE_MAX_RST;
      cfg.gas_full_volt          <= hcl_pkg::GAS_FULL_RST;
      cfg.knee_level             <= hcl_pkg::KNEE_LEVEL_RST;
      cfg.turn_center_volt       <= hcl_pkg::TURN_CENTER_RST;
      cfg.turn_high_volt         <= hcl_pkg::TURN_HIGH_RST;
      cfg.turn_low_volt          <= hcl_pkg::TURN_LOW_RST;
    end else if (cfg_wr_en) begin
      case (hcl_pkg::cfg_idx_t'(cfg_index))
        hcl_pkg::CFG_GAS_DEAD_LOW:    cfg.gas_dead_low_volt      <= VW'(cfg_data);
        hcl_pkg::CFG_REVERSE_THR:     cfg.reverse_threshold_volt <= VW'(cfg_data);
        hcl_pkg::CFG_GAS_REVERSE_MAX: cfg.gas_reverse_max_volt   <= VW'(cfg_data);
        hcl_pkg::CFG_GAS_FULL:        cfg.gas_full_volt          <= VW'(cfg_data);
        hcl_pkg::CFG_KNEE_LEVEL:      cfg.knee_level             <= KW'(cfg_data);
        hcl_pkg::CFG_TURN_CENTER:     cfg.turn_center_volt       <= VW'(cfg_data);
        hcl_pkg::CFG_TURN_HIGH:       cfg.turn_high_volt         <= VW'(cfg_data);
        hcl_pkg::CFG_TURN_LOW:        cfg.turn_low_volt          <= VW'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  hcl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  hcl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hcl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .levels    (levels)
  );

endmodule

`default_nettype wire
